/* sv/mbf_pkg.sv */
// Shared constants, types and derived widths for the metaball field evaluator.
package mbf_pkg;

    localparam int MAX_BALLS       = 16;
    localparam int CELL_COORD_BITS = 9;

    localparam int FRAC_POS   = 6;
    localparam int BALL_POS_W = 16;
    localparam int SCALE_W    = 8;
    localparam int SLOT_W     = 4;
    localparam int ACT_W      = 5;
    localparam int THRESH_W   = 24;
    localparam int TERM_W     = 24;
    localparam logic [TERM_W-1:0] SUM_MAX = '1;
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(65536);

    localparam int SQRT_SHIFT     = 20;
    localparam int DIVIDEND_SHIFT = 32;

    localparam int POS_W  = (CELL_COORD_BITS + FRAC_POS > BALL_POS_W) ?
                            CELL_COORD_BITS + FRAC_POS : BALL_POS_W;
    localparam int D2_W   = 2 * POS_W + 1;
    localparam int ROOT_W = (D2_W + SQRT_SHIFT + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;

    localparam int TREE_LVLS = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
    localparam int LEAVES    = 1 << TREE_LVLS;
    localparam int SUM_W     = TERM_W + TREE_LVLS;

    // lane: diff, square, add, sqrt stages, divide setup, divide stages
    localparam int LANE_LAT = 3 + ROOT_W + 1 + TERM_W;
    localparam int PIPE_LAT = LANE_LAT + TREE_LVLS;

    localparam int IN_FIELDS_W = SLOT_W + 2 * BALL_POS_W + SCALE_W + 2 * CELL_COORD_BITS;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = TERM_W;
    localparam int OUT_USER_W  = 2;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = THRESH_W;

    typedef enum logic [0:0] {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } func_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ACTIVE_BALLS  = 1'b0,
        REG_INSIDE_THRESH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [BALL_POS_W-1:0] x;
        logic [BALL_POS_W-1:0] y;
        logic [SCALE_W-1:0]    scale;
    } ball_t;

    typedef struct packed {
        logic              sat;
        logic [TERM_W-1:0] term;
    } lane_res_t;

endpackage

/* sv/mbf_sqrt.sv */
// Pipelined floor square root, one root bit per stage.
module mbf_sqrt (
    input  logic                        aclk,
    input  logic                        adv,
    input  logic [mbf_pkg::RAD_W-1:0]   rad,
    output logic [mbf_pkg::ROOT_W-1:0]  root
);
    import mbf_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        always_comb begin
            rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
            trial  = {root_in, 2'b01};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= {rad_in[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

/* sv/mbf_div.sv */
// Pipelined restoring divider: scale * 2^32 / distance, one quotient bit per stage.
module mbf_div (
    input  logic                         aclk,
    input  logic                         adv,
    input  logic [mbf_pkg::ROOT_W-1:0]   divisor,
    input  logic [mbf_pkg::SCALE_W-1:0]  scale,
    output logic [mbf_pkg::TERM_W-1:0]   quot,
    output logic                         ovf
);
    import mbf_pkg::*;

    localparam int REMD_W = ROOT_W + 1;

    logic [REMD_W-1:0] rem_reg  [TERM_W+1];
    logic [TERM_W-1:0] quot_reg [TERM_W+1];
    logic [ROOT_W-1:0] dvs_reg  [TERM_W+1];
    logic              ovf_reg  [TERM_W+1];

    logic [REMD_W-1:0] rem_init;

    // top of the dividend; quotient overflows 24 bits when it is not below divisor
    assign rem_init = REMD_W'({scale, {(DIVIDEND_SHIFT - TERM_W){1'b0}}});

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= rem_init;
            quot_reg[0] <= '0;
            dvs_reg[0]  <= divisor;
            ovf_reg[0]  <= rem_init >= REMD_W'(divisor);
        end
    end

    for (genvar j = 1; j <= TERM_W; j++) begin : g_step
        logic [REMD_W-1:0] rem_sh;
        logic [REMD_W-1:0] dvs_ext;
        logic              ge;

        always_comb begin
            rem_sh  = {rem_reg[j-1][REMD_W-2:0], 1'b0};
            dvs_ext = {1'b0, dvs_reg[j-1]};
            ge      = rem_sh >= dvs_ext;
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[j]  <= ge ? rem_sh - dvs_ext : rem_sh;
                quot_reg[j] <= {quot_reg[j-1][TERM_W-2:0], ge};
                dvs_reg[j]  <= dvs_reg[j-1];
                ovf_reg[j]  <= ovf_reg[j-1];
            end
        end
    end

    assign quot = quot_reg[TERM_W];
    assign ovf  = ovf_reg[TERM_W];

endmodule

/* sv/mbf_lane.sv */
// One ball lane: distance squared, square root and scale divide for each cell.
module mbf_lane (
    input  logic                        aclk,
    input  logic                        adv,
    input  mbf_pkg::ball_t              ball,
    input  logic [mbf_pkg::POS_W-1:0]   cell_xpos,
    input  logic [mbf_pkg::POS_W-1:0]   cell_ypos,
    input  logic                        use_in,
    output mbf_pkg::lane_res_t          res
);
    import mbf_pkg::*;

    localparam int USE_DLY = ROOT_W + 1 + TERM_W;

    logic [POS_W-1:0]   dx_reg, dy_reg;
    logic [SCALE_W-1:0] sc1_reg, sc2_reg, sc3_reg;
    logic               use1_reg, use2_reg, use3_reg;
    logic [2*POS_W-1:0] sqx_reg, sqy_reg;
    logic [D2_W-1:0]    d2_reg;
    logic [SCALE_W-1:0] scale_dly_reg [ROOT_W];
    logic               use_dly_reg   [USE_DLY];

    logic [POS_W-1:0]   bx, by;
    logic [ROOT_W-1:0]  root;
    logic [TERM_W-1:0]  quot;
    logic               ovf;

    assign bx = POS_W'(ball.x);
    assign by = POS_W'(ball.y);

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg   <= (bx >= cell_xpos) ? bx - cell_xpos : cell_xpos - bx;
            dy_reg   <= (by >= cell_ypos) ? by - cell_ypos : cell_ypos - by;
            sc1_reg  <= ball.scale;
            use1_reg <= use_in;

            sqx_reg  <= (2*POS_W)'(dx_reg) * (2*POS_W)'(dx_reg);
            sqy_reg  <= (2*POS_W)'(dy_reg) * (2*POS_W)'(dy_reg);
            sc2_reg  <= sc1_reg;
            use2_reg <= use1_reg;

            d2_reg   <= D2_W'(sqx_reg) + D2_W'(sqy_reg);
            sc3_reg  <= sc2_reg;
            use3_reg <= use2_reg;

            scale_dly_reg[0] <= sc3_reg;
            for (int k = 1; k < ROOT_W; k++) begin
                scale_dly_reg[k] <= scale_dly_reg[k-1];
            end
            use_dly_reg[0] <= use3_reg;
            for (int k = 1; k < USE_DLY; k++) begin
                use_dly_reg[k] <= use_dly_reg[k-1];
            end
        end
    end

    mbf_sqrt u_sqrt (
        .aclk (aclk),
        .adv  (adv),
        .rad  (RAD_W'({d2_reg, {SQRT_SHIFT{1'b0}}})),
        .root (root)
    );

    // zero distance gives a zero root, which always flags overflow here
    mbf_div u_div (
        .aclk    (aclk),
        .adv     (adv),
        .divisor (root),
        .scale   (scale_dly_reg[ROOT_W-1]),
        .quot    (quot),
        .ovf     (ovf)
    );

    always_comb begin
        res.sat  = use_dly_reg[USE_DLY-1] && ovf;
        res.term = (use_dly_reg[USE_DLY-1] && !ovf) ? quot : '0;
    end

endmodule

/* sv/mbf_sum.sv */
// Registered adder tree over the lane terms, with the saturation flags or-ed along.
module mbf_sum (
    input  logic                        aclk,
    input  logic                        adv,
    input  mbf_pkg::lane_res_t          lanes [mbf_pkg::MAX_BALLS],
    output logic [mbf_pkg::SUM_W-1:0]   tot_sum,
    output logic                        tot_sat
);
    import mbf_pkg::*;

    logic [SUM_W-1:0] leaf_sum [LEAVES];
    logic             leaf_sat [LEAVES];
    logic [SUM_W-1:0] node_sum_reg [LEAVES-1];
    logic             node_sat_reg [LEAVES-1];

    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < MAX_BALLS) begin : g_used
            assign leaf_sum[i] = SUM_W'(lanes[i].term);
            assign leaf_sat[i] = lanes[i].sat;
        end else begin : g_pad
            assign leaf_sum[i] = '0;
            assign leaf_sat[i] = 1'b0;
        end
    end

    // heap order: node n has children 2n+1 and 2n+2, leaves follow the last node
    for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
        localparam int C0 = 2 * n + 1;
        localparam int C1 = 2 * n + 2;
        logic [SUM_W-1:0] a_sum, b_sum;
        logic             a_sat, b_sat;

        if (C0 >= LEAVES - 1) begin : g_from_leaf
            assign a_sum = leaf_sum[C0 - (LEAVES - 1)];
            assign a_sat = leaf_sat[C0 - (LEAVES - 1)];
            assign b_sum = leaf_sum[C1 - (LEAVES - 1)];
            assign b_sat = leaf_sat[C1 - (LEAVES - 1)];
        end else begin : g_from_node
            assign a_sum = node_sum_reg[C0];
            assign a_sat = node_sat_reg[C0];
            assign b_sum = node_sum_reg[C1];
            assign b_sat = node_sat_reg[C1];
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                node_sum_reg[n] <= a_sum + b_sum;
                node_sat_reg[n] <= a_sat || b_sat;
            end
        end
    end

    assign tot_sum = node_sum_reg[0];
    assign tot_sat = node_sat_reg[0];

endmodule

/* sv/metaball_field_evaluator.sv */
// A cell beat passes the diff, square and add registers, the one-bit-per-stage square root,
// the divide setup and divide stages, the adder tree levels and an output register to its result beat.
// Throughput: one beat per cycle, loads and cells alike; a load writes the ball table
// and gives no result. The whole pipeline holds while a result beat waits on m_tready.
// Reset (synchronous, aresetn low): ball table zeroed, active_balls 0, threshold 1.0,
// pipeline and output emptied.
module metaball_field_evaluator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // ball_slot, ball_x, ball_y, ball_scale, cell_x, cell_y (lowest bit up), zero pad
    input  logic [mbf_pkg::IN_DATA_W-1:0]     s_tdata,
    // func
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // field_sum
    output logic [mbf_pkg::OUT_DATA_W-1:0]    m_tdata,
    // inside_res, saturated (lowest bit up)
    output logic [mbf_pkg::OUT_USER_W-1:0]    m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [mbf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mbf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import mbf_pkg::*;

    localparam int OFS_SLOT  = 0;
    localparam int OFS_X     = OFS_SLOT + SLOT_W;
    localparam int OFS_Y     = OFS_X + BALL_POS_W;
    localparam int OFS_SCALE = OFS_Y + BALL_POS_W;
    localparam int OFS_CX    = OFS_SCALE + SCALE_W;
    localparam int OFS_CY    = OFS_CX + CELL_COORD_BITS;
    localparam int CMP_W     = (ACT_W > $clog2(MAX_BALLS) + 1) ? ACT_W : $clog2(MAX_BALLS) + 1;

    logic [ACT_W-1:0]      act_reg;
    logic [THRESH_W-1:0]   thresh_reg;
    ball_t                 tbl_reg [MAX_BALLS];
    logic                  vld_reg [PIPE_LAT];
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_USER_W-1:0] m_tuser_reg;

    logic                  adv;
    logic                  in_beat;
    logic                  ld;
    logic [SLOT_W-1:0]     in_slot;
    ball_t                 in_ball;
    logic [POS_W-1:0]      cell_xpos, cell_ypos;
    lane_res_t             lane_res [MAX_BALLS];
    logic [SUM_W-1:0]      tot_sum;
    logic                  tot_sat;
    logic                  clip_sat;
    logic [TERM_W-1:0]     field_next;
    logic                  inside_next;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign in_beat  = s_tvalid && adv;
    assign ld       = in_beat && (func_t'(s_tuser) == FUNC_LOAD);

    assign in_slot       = s_tdata[OFS_SLOT +: SLOT_W];
    assign in_ball.x     = s_tdata[OFS_X +: BALL_POS_W];
    assign in_ball.y     = s_tdata[OFS_Y +: BALL_POS_W];
    assign in_ball.scale = s_tdata[OFS_SCALE +: SCALE_W];
    assign cell_xpos     = POS_W'({s_tdata[OFS_CX +: CELL_COORD_BITS], {FRAC_POS{1'b0}}});
    assign cell_ypos     = POS_W'({s_tdata[OFS_CY +: CELL_COORD_BITS], {FRAC_POS{1'b0}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg    <= '0;
            thresh_reg <= THRESH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_ACTIVE_BALLS:  act_reg    <= cfg_wdata[ACT_W-1:0];
                REG_INSIDE_THRESH: thresh_reg <= cfg_wdata[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < MAX_BALLS; i++) begin : g_ball
        logic lane_use;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tbl_reg[i] <= '0;
            end else if (ld && CMP_W'(in_slot) == CMP_W'(i)) begin
                tbl_reg[i] <= in_ball;
            end
        end

        assign lane_use = CMP_W'(i) < CMP_W'(act_reg);

        mbf_lane u_lane (
            .aclk      (aclk),
            .adv       (adv),
            .ball      (tbl_reg[i]),
            .cell_xpos (cell_xpos),
            .cell_ypos (cell_ypos),
            .use_in    (lane_use),
            .res       (lane_res[i])
        );
    end

    mbf_sum u_sum (
        .aclk    (aclk),
        .adv     (adv),
        .lanes   (lane_res),
        .tot_sum (tot_sum),
        .tot_sat (tot_sat)
    );

    always_comb begin
        clip_sat    = tot_sat || (tot_sum > SUM_W'(SUM_MAX));
        field_next  = clip_sat ? SUM_MAX : tot_sum[TERM_W-1:0];
        inside_next = field_next > thresh_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PIPE_LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_beat && (func_t'(s_tuser) == FUNC_EVAL);
            for (int k = 1; k < PIPE_LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            m_tvalid_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= field_next;
            m_tuser_reg <= {clip_sat, inside_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_sat_clips: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg[1] |-> m_tdata_reg == SUM_MAX)
        else $error("saturated beat without clipped sum");

    a_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> m_tuser_reg[0] == (m_tdata_reg > thresh_reg))
        else $error("inside flag disagrees with threshold");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg[PIPE_LAT-1]) && $stable(tot_sum))
        else $error("pipeline moved during stall");

endmodule

/* tb/field_checker.sv */
// Checker for the metaball field evaluator: predicts cell results and compares them.
module field_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [mbf_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [mbf_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic [mbf_pkg::OUT_USER_W-1:0]    m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [mbf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mbf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output int                                fail_count,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mbf_pkg::*;

    typedef struct packed {
        logic [TERM_W-1:0] sum;
        logic              in_flag;
        logic              sat;
    } cell_res_t;

    ball_t             balls [MAX_BALLS];
    logic [ACT_W-1:0]    n_active;
    logic [THRESH_W-1:0] thresh;
    cell_res_t         field_q[$];

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic cell_res_t eval_cell(logic [8:0] cx, logic [8:0] cy);
        longint unsigned px, py, dx, dy, d2, s, sum;
        logic sat;
        int cnt;
        cell_res_t r;
        px = longint'(cx) << FRAC_POS;
        py = longint'(cy) << FRAC_POS;
        sum = 0;
        sat = 0;
        cnt = (n_active > MAX_BALLS) ? MAX_BALLS : n_active;
        for (int i = 0; i < cnt; i++) begin
            dx = (balls[i].x >= px) ? balls[i].x - px : px - balls[i].x;
            dy = (balls[i].y >= py) ? balls[i].y - py : py - balls[i].y;
            d2 = dx * dx + dy * dy;
            if (d2 == 0) begin
                sat = 1;
            end else begin
                s = isqrt(d2 << 20);
                sum = sum + ((longint'(balls[i].scale) << 32) / s);
                if (sum > 64'hFFFFFF) sum = 64'h1000000;
            end
        end
        if (sat || sum > 64'hFFFFFF) begin
            sum = 64'hFFFFFF;
            sat = 1;
        end
        r.sum = sum[23:0];
        r.in_flag = (sum > thresh);
        r.sat = sat;
        return r;
    endfunction

    assign pending = field_q.size();

    always_ff @(posedge aclk) begin
        cell_res_t e;
        if (!aresetn) begin
            foreach (balls[i]) balls[i] <= '0;
            n_active <= '0;
            thresh <= THRESH_RESET;
            fail_count <= 0;
            field_q.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_ACTIVE_BALLS) n_active <= cfg_wdata[ACT_W-1:0];
                else if (cfg_addr == REG_INSIDE_THRESH) thresh <= cfg_wdata;
            end
            if (m_tvalid && m_tready) begin
                if (field_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected result beat %h", m_tdata);
                end else begin
                    e = field_q.pop_front();
                    if (e.sum !== m_tdata || e.in_flag !== m_tuser[0] || e.sat !== m_tuser[1])
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: exp sum %h in %b sat %b, got %h in %b sat %b",
                                     e.sum, e.in_flag, e.sat, m_tdata, m_tuser[0], m_tuser[1]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == FUNC_LOAD)
                    balls[s_tdata[3:0]] <= {s_tdata[19:4], s_tdata[35:20], s_tdata[43:36]};
                else
                    field_q.insert(field_q.size(), eval_cell(s_tdata[52:44], s_tdata[61:53]));
            end
        end
    end
endmodule

/* tb/testbench.sv */
// Testbench top: stimulus, configuration phases and verdict for the field evaluator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mbf_pkg::*;

    logic aclk, aresetn;
    logic s_tvalid, s_tready, s_tuser;
    logic [IN_DATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int fail_count, pending, idle_cycles;
    int s_idle_pct, m_idle_pct;

    metaball_field_evaluator u_top (.*);
    field_checker u_chk (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // receiver stall
    always @(posedge aclk) m_tready <= ($urandom_range(99) >= m_idle_pct);

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic send(logic f, logic [3:0] slot, logic [15:0] bx, logic [15:0] by,
                        logic [7:0] sc, logic [8:0] cx, logic [8:0] cy);
        while (s_idle_pct > 0 && $urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= f;
        s_tdata <= IN_DATA_W'({cy, cx, sc, by, bx, slot});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (PIPE_LAT + 10) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
        cfg_wr_en <= 1;
        cfg_addr <= r;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    task automatic rand_load();
        logic [8:0] cx, cy;
        cx = 9'($urandom_range(511));
        cy = 9'($urandom_range(511));
        // mostly balls near the grid, sometimes anywhere
        if ($urandom_range(3) == 0)
            send(FUNC_LOAD, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                 9'($urandom), 9'($urandom));
        else
            send(FUNC_LOAD, 4'($urandom), {cx[8:0], 6'($urandom)} + 16'($urandom_range(2000)),
                 16'({cy, 6'($urandom)}), 8'($urandom), 9'($urandom), 9'($urandom));
    endtask

    task automatic rand_cell();
        send(FUNC_EVAL, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
             9'($urandom), 9'($urandom));
    endtask

    initial begin
        s_tvalid = 0; s_tuser = 0; s_tdata = '0;
        cfg_wr_en = 0; cfg_addr = REG_ACTIVE_BALLS; cfg_wdata = '0;
        s_idle_pct = 0; m_idle_pct = 0;
        aresetn = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reset state, zero distance, extremes
        send(FUNC_EVAL, 0, 0, 0, 0, 0, 0);
        drain();
        write_reg(REG_ACTIVE_BALLS, 2);
        send(FUNC_EVAL, 0, 0, 0, 0, 0, 0);
        send(FUNC_LOAD, 0, 16'h0040, 16'h0040, 8'hFF, 0, 0);
        send(FUNC_LOAD, 1, 16'hFFFF, 16'hFFFF, 8'h01, 0, 0);
        send(FUNC_LOAD, 4'hF, 16'h1000, 16'h2000, 8'h80, 0, 0);
        send(FUNC_EVAL, 0, 0, 0, 0, 1, 1);
        send(FUNC_EVAL, 0, 0, 0, 0, 2, 1);
        send(FUNC_EVAL, 0, 0, 0, 0, 511, 511);
        send(FUNC_EVAL, 0, 0, 0, 0, 0, 511);
        send(FUNC_LOAD, 1, 16'h0080, 16'h0040, 8'h00, 0, 0);
        send(FUNC_EVAL, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF, 2, 1);
        send(FUNC_EVAL, 0, 0, 0, 0, 3, 1);
        drain();
        write_reg(REG_ACTIVE_BALLS, 31);
        write_reg(REG_INSIDE_THRESH, 24'hFFFFFF);
        send(FUNC_EVAL, 0, 0, 0, 0, 5, 5);
        send(FUNC_EVAL, 0, 0, 0, 0, 64, 64);
        drain();
        write_reg(REG_INSIDE_THRESH, 0);
        send(FUNC_EVAL, 0, 0, 0, 0, 300, 2);
        send(FUNC_EVAL, 0, 0, 0, 0, 100, 100);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            s_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 69 : 0;
            m_idle_pct = (ph < 2) ? 69 : (ph < 4) ? 34 : 0;
            case (ph)
                0: begin write_reg(REG_ACTIVE_BALLS, 16);
                         write_reg(REG_INSIDE_THRESH, THRESH_RESET); end
                1: begin write_reg(REG_ACTIVE_BALLS, 0); end
                2: begin write_reg(REG_ACTIVE_BALLS, CFG_DATA_W'($urandom_range(1, 15)));
                         write_reg(REG_INSIDE_THRESH, CFG_DATA_W'($urandom)); end
                3: begin write_reg(REG_ACTIVE_BALLS, 20);
                         write_reg(REG_INSIDE_THRESH, 24'h000100); end
                4: begin write_reg(REG_ACTIVE_BALLS, 1);
                         write_reg(REG_INSIDE_THRESH, 24'h020000); end
                default: begin write_reg(REG_ACTIVE_BALLS, 16);
                         write_reg(REG_INSIDE_THRESH, 24'h080000); end
            endcase
            for (int i = 0; i < 80; i++) begin
                if ($urandom_range(3) == 0) rand_load();
                else rand_cell();
                if (i == 40 && ph == 0) drain();
            end
            drain();
        end

        if (fail_count == 0) $display("testbench: done, clean");
        else $display("testbench: done, errors");
        $finish;
    end
endmodule
